// File: hw/rtl/cmbi_pkg.sv
package cmbi_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Counter bit that drives the interrupt line.
	localparam int IRQ_BIT = 12;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_OUTER_PORT_ENABLE = 1'b0;

	// Address windows, by the top three address bits (8K slots); the IRQ window by the top two.
	localparam logic [2:0] SLOT_WRAM   = 3'd3;
	localparam logic [2:0] SLOT_OUTER  = 3'd6;
	localparam logic [2:0] SLOT_BANK   = 3'd7;
	localparam logic [1:0] WIN_IRQ_ENA = 2'b10;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] cpu_addr;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [3:0] prg_page;
		logic       page_mapped;
		logic [6:0] chr_bank;
		logic       mirror_horizontal;
		logic       irq_asserted;
	} rsp_t;

	// 8K PRG page for a slot at or above the work RAM window.
	function automatic logic [3:0] page_for(
		input logic [2:0] slot,
		input logic [2:0] bank,
		input logic [7:0] outer
	);
		logic [3:0] page;
		page = 4'd7;
		if (slot == SLOT_WRAM || !outer[3]) begin
			unique case (slot)
				3'd3:    page = 4'd6;
				3'd4:    page = 4'd4;
				3'd5:    page = 4'd5;
				3'd6:    page = {1'b0, bank};
				default: page = 4'd7;
			endcase
		end else if (outer[4]) begin
			// 32K mode: bank 2 or 3 covers the whole upper half.
			page = {(2'b10 | outer[7:6]), slot[1:0]};
		end else begin
			// 16K mode: the same bank appears at 0x8000 and at 0xC000.
			page = {(3'b100 | outer[7:5]), slot[0]};
		end
		return page;
	endfunction

endpackage

// File: hw/rtl/cmbi_regs.sv
module cmbi_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cmbi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cmbi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cmbi_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output logic                             outer_port_enable
);
	import cmbi_pkg::*;

	logic outer_port_enable_q;
	logic sel_outer;

	assign pready = 1'b1;
	assign sel_outer = (paddr[APB_ADDR_W-1] == REG_OUTER_PORT_ENABLE);

	// Register write in the access phase of a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_port_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && sel_outer) begin
			outer_port_enable_q <= pwdata[0];
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		if (sel_outer) begin
			prdata = {{(APB_DATA_W-1){1'b0}}, outer_port_enable_q};
		end
	end

	assign outer_port_enable = outer_port_enable_q;

endmodule

// File: hw/rtl/cmbi_core.sv
module cmbi_core #(
	parameter int IRQ_BIT = cmbi_pkg::IRQ_BIT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           outer_port_enable,
	input  logic           req_valid,
	output logic           req_ready,
	input  cmbi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cmbi_pkg::rsp_t rsp
);
	import cmbi_pkg::*;

	// Pipeline registers.
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;

	// Mapper state.
	logic [2:0]  bank_select_q;
	logic [7:0]  outer_select_q;
	logic        irq_enable_q;
	logic [15:0] cycle_count_q;
	logic        irq_line_q;

	logic [2:0]  bank_select_d;
	logic [7:0]  outer_select_d;
	logic        irq_enable_d;
	logic [15:0] cycle_count_d;
	logic        irq_line_d;
	rsp_t        rsp_d;
	logic [2:0]  slot;
	logic        advance;

	// The stage-one transaction moves on whenever the result register is empty or its result is taken.
	assign advance   = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign slot      = req_s1.cpu_addr[15:13];

	// Next state and result for the transaction in stage one.
	always_comb begin
		bank_select_d  = bank_select_q;
		outer_select_d = outer_select_q;
		irq_enable_d   = irq_enable_q;
		cycle_count_d  = cycle_count_q;
		irq_line_d     = irq_line_q;
		rsp_d          = '0;

		unique case (req_s1.op)
			OP_WRITE: begin
				if (req_s1.cpu_addr[15:14] == WIN_IRQ_ENA) begin
					irq_enable_d = req_s1.cpu_addr[13];
				end else if (slot == SLOT_BANK) begin
					bank_select_d = req_s1.write_data[2:0];
				end else if (slot == SLOT_OUTER && outer_port_enable) begin
					outer_select_d = req_s1.cpu_addr[7:0];
				end
			end
			OP_TICK: begin
				if (irq_enable_q) begin
					cycle_count_d = cycle_count_q + 16'd1;
					irq_line_d    = cycle_count_d[IRQ_BIT];
				end else begin
					cycle_count_d = '0;
					irq_line_d    = 1'b0;
				end
			end
			OP_LOOKUP: begin
				if (slot >= SLOT_WRAM) begin
					rsp_d.page_mapped = 1'b1;
					rsp_d.prg_page    = page_for(slot, bank_select_q, outer_select_q);
				end
			end
			default: begin
				// The unused code changes nothing.
			end
		endcase

		rsp_d.chr_bank          = outer_select_d[7:1];
		rsp_d.mirror_horizontal = outer_select_d[0];
		rsp_d.irq_asserted      = irq_line_d;
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			bank_select_q  <= '0;
			outer_select_q <= '0;
			irq_enable_q   <= 1'b0;
			cycle_count_q  <= '0;
			irq_line_q     <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				bank_select_q  <= bank_select_d;
				outer_select_q <= outer_select_d;
				irq_enable_q   <= irq_enable_d;
				cycle_count_q  <= cycle_count_d;
				irq_line_q     <= irq_line_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance && valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

// File: hw/rtl/cartridge_mapper_bank_irq_top.sv
// Cartridge bank mapper with a cycle-counting interrupt.
// The request channel (req_valid, req_ready, req) carries one transaction per
// CPU write, CPU-cycle tick or address lookup. The response channel
// (rsp_valid, rsp_ready, rsp) returns exactly one result per request, in order,
// with the PRG page of a lookup and the CHR bank, mirroring and IRQ line as
// they stand after the request has been applied.
// A request is registered in the input register on acceptance, and its result
// is registered in the output register once that register is empty or read.
// One request is accepted every cycle while the receiver does not stall; the
// state update and result logic between the two registers sets that figure.
// When the receiver stalls, the result stays in the output register and one
// more request can be held in the input register; req_ready falls only when
// both are full.
// Reset clears all mapper state, the interrupt counter and the configuration
// register, and empties both pipeline stages.
// The APB port holds one register, outer_port_enable, at byte address 0.
module cartridge_mapper_bank_irq_top #(
	parameter int IRQ_BIT = cmbi_pkg::IRQ_BIT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cmbi_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cmbi_pkg::APB_DATA_W-1:0] pwdata,
	output logic [cmbi_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  cmbi_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output cmbi_pkg::rsp_t                   rsp
);
	import cmbi_pkg::*;

	logic outer_port_enable;

	cmbi_regs u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.outer_port_enable (outer_port_enable)
	);

	cmbi_core #(
		.IRQ_BIT (IRQ_BIT)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.outer_port_enable (outer_port_enable),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.req               (req),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.rsp               (rsp)
	);

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cmbi_pkg::*;

	// Operation code that the mapper leaves without effect.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// CPU address windows.
	localparam logic [15:0] ADDR_WRAM_LO  = 16'h6000;
	localparam logic [15:0] ADDR_IRQ_LO   = 16'h8000;
	localparam logic [15:0] ADDR_IRQ_HI   = 16'hBFFF;
	localparam logic [15:0] ADDR_OUTER_LO = 16'hC000;
	localparam logic [15:0] ADDR_BANK_LO  = 16'hE000;

	// Byte address of the single configuration register.
	localparam logic [APB_ADDR_W-1:0] CFG_ADDR_OUTER_PORT_ENABLE =
		{REG_OUTER_PORT_ENABLE, 2'b00};

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 400;
	localparam int BURST_ITEMS = 300;
	localparam int LONG_HOLD = 300;

	// Scoreboard: keeps its own copy of the mapper state and queues the
	// expected result of every accepted transaction.
	class mapper_scoreboard;
		rsp_t expected_rsp[$];
		int mismatches;
		bit outer_port_en;
		logic [2:0] bank_sel;
		logic [7:0] outer_reg;
		logic irq_en;
		logic [15:0] tick_count;
		logic irq_out;

		function new();
			mismatches = 0;
			outer_port_en = 0;
			bank_sel = '0;
			outer_reg = '0;
			irq_en = 0;
			tick_count = '0;
			irq_out = 0;
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			if (mismatches <= 50)
				$display("mismatch %0d at %0t: %s got %0h expected %0h",
					mismatches, $realtime, what, got, want);
		endfunction

		// PRG page of a lookup at or above the work RAM window.
		function logic [3:0] page_of(logic [15:0] addr);
			int slot;
			int blk;
			slot = int'(addr[15:13]);
			if (slot == 3 || !outer_reg[3]) begin
				case (slot)
					3: return 4'd6;
					4: return 4'd4;
					5: return 4'd5;
					6: return {1'b0, bank_sel};
					default: return 4'd7;
				endcase
			end
			if (outer_reg[4]) begin
				blk = 2 | (outer_reg >> 6);
				return 4'(((blk << 2) | (slot & 3)) & 15);
			end
			blk = 4 | (outer_reg >> 5);
			return 4'(((blk << 1) | (slot & 1)) & 15);
		endfunction

		// Apply one accepted transaction and queue the result it must produce.
		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			case (r.op)
				OP_WRITE: begin
					if (r.cpu_addr >= ADDR_IRQ_LO && r.cpu_addr <= ADDR_IRQ_HI)
						irq_en = r.cpu_addr[13];
					else if (r.cpu_addr >= ADDR_BANK_LO)
						bank_sel = r.write_data[2:0];
					else if (r.cpu_addr >= ADDR_OUTER_LO && outer_port_en)
						outer_reg = r.cpu_addr[7:0];
				end
				OP_TICK: begin
					if (irq_en) begin
						tick_count = tick_count + 16'd1;
						irq_out = tick_count[IRQ_BIT];
					end else begin
						tick_count = '0;
						irq_out = 0;
					end
				end
				OP_LOOKUP: begin
					if (r.cpu_addr >= ADDR_WRAM_LO) begin
						e.page_mapped = 1'b1;
						e.prg_page = page_of(r.cpu_addr);
					end
				end
				default: ;
			endcase
			e.chr_bank = outer_reg[7:1];
			e.mirror_horizontal = outer_reg[0];
			e.irq_asserted = irq_out;
			expected_rsp.push_back(e);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				report("result with nothing expected", 32'(got), 32'd0);
				return;
			end
			e = expected_rsp.pop_front();
			if (got.prg_page !== e.prg_page)
				report("prg_page", 32'(got.prg_page), 32'(e.prg_page));
			if (got.page_mapped !== e.page_mapped)
				report("page_mapped", 32'(got.page_mapped), 32'(e.page_mapped));
			if (got.chr_bank !== e.chr_bank)
				report("chr_bank", 32'(got.chr_bank), 32'(e.chr_bank));
			if (got.mirror_horizontal !== e.mirror_horizontal)
				report("mirror_horizontal", 32'(got.mirror_horizontal),
					32'(e.mirror_horizontal));
			if (got.irq_asserted !== e.irq_asserted)
				report("irq_asserted", 32'(got.irq_asserted), 32'(e.irq_asserted));
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	mapper_scoreboard sb;
	bit fast_mode;
	int send_calm;
	int recv_calm;
	int n_results;
	int cycles;

	cartridge_mapper_bank_irq_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle cycles before the next transaction; now and then a calm stretch.
	function automatic int draw_gap(ref int calm_left);
		if (fast_mode)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 6);
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
		req_t r;
		r.op = op;
		r.cpu_addr = addr;
		r.write_data = data;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.op = OP_WRITE;
		else if (pick < 62)
			r.op = OP_TICK;
		else if (pick < 95)
			r.op = OP_LOOKUP;
		else
			r.op = OP_RESERVED;
		// Window boundaries get extra weight.
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 9))
				0: r.cpu_addr = 16'h0000;
				1: r.cpu_addr = 16'h5FFF;
				2: r.cpu_addr = 16'h6000;
				3: r.cpu_addr = 16'h7FFF;
				4: r.cpu_addr = 16'h8000;
				5: r.cpu_addr = 16'hBFFF;
				6: r.cpu_addr = 16'hC000;
				7: r.cpu_addr = 16'hDFFF;
				8: r.cpu_addr = 16'hE000;
				default: r.cpu_addr = 16'hFFFF;
			endcase
		end else begin
			r.cpu_addr = 16'($urandom_range(0, 65535));
		end
		r.write_data = 8'($urandom_range(0, 255));
		return r;
	endfunction

	// Offer one transaction and wait until it is accepted.
	task automatic send_item(req_t r);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
	endtask

	task automatic stop_req();
		req_valid <= 1'b0;
	endtask

	// Wait until every expected result has come, then let the pipeline settle.
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_ADDR_OUTER_PORT_ENABLE;
		pwdata <= {{(APB_DATA_W - 1){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.outer_port_en = value;
	endtask

	// Result side: random stalls, plus two long hold-offs that fill the block.
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			sb.check_result(rsp);
			n_results++;
			if (n_results == 15 || n_results == 1000) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
		end
	end

	// Watchdog.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		sb = new();
		fast_mode = 0;
		send_calm = 0;
		recv_calm = 0;
		n_results = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the outer port disabled.
		cfg_write(1'b0);
		send_item(make_req(OP_LOOKUP, 16'h0000, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'h5FFF, 8'hFF));
		send_item(make_req(OP_WRITE, 16'hC0FF, 8'hFF));
		send_item(make_req(OP_LOOKUP, 16'h6000, 8'h00));
		send_item(make_req(OP_RESERVED, 16'hFFFF, 8'hFF));
		send_item(make_req(OP_WRITE, 16'h7FFF, 8'h07));
		stop_req();
		drain();

		// Directed part with the outer port enabled: bank, both outer modes, IRQ.
		cfg_write(1'b1);
		send_item(make_req(OP_WRITE, 16'hFFFF, 8'hFF));
		send_item(make_req(OP_LOOKUP, 16'hC000, 8'h00));
		send_item(make_req(OP_WRITE, 16'hC0FF, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'h8000, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'hFFFF, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'h6000, 8'h00));
		send_item(make_req(OP_WRITE, 16'hDFE8, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'hA000, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'hE000, 8'h00));
		send_item(make_req(OP_WRITE, 16'hC000, 8'h00));
		send_item(make_req(OP_LOOKUP, 16'hC000, 8'h00));
		send_item(make_req(OP_WRITE, 16'hA000, 8'h00));
		send_item(make_req(OP_TICK, 16'h0000, 8'h00));
		send_item(make_req(OP_WRITE, 16'h8000, 8'h00));
		send_item(make_req(OP_TICK, 16'hFFFF, 8'hFF));
		send_item(make_req(OP_WRITE, 16'hBFFF, 8'h00));

		// Back-to-back burst of mostly ticks while the IRQ counter is enabled.
		fast_mode = 1;
		for (int i = 0; i < BURST_ITEMS; i++) begin
			if ($urandom_range(0, 63) != 0)
				send_item(make_req(OP_TICK, 16'($urandom_range(0, 65535)), 8'h00));
			else if ($urandom_range(0, 1) == 0)
				send_item(make_req(OP_LOOKUP, 16'($urandom_range(0, 65535)), 8'h00));
			else
				send_item(make_req(OP_WRITE, 16'($urandom_range(16'hC000, 16'hFFFF)),
					8'($urandom_range(0, 255))));
		end
		fast_mode = 0;
		stop_req();

		// Random phases over both settings of the outer port.
		for (int p = 0; p < 4; p++) begin
			drain();
			cfg_write(p % 2 == 0);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (p == 1 && i == 200) begin
					stop_req();
					while (sb.pending() != 0) @(posedge clk);
				end
				send_item(random_request());
			end
			stop_req();
		end

		// Let the last results arrive, then allow for anything extra.
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("expectations left over", sb.pending(), 0);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: cartridge_mapper_bank_irq_top.f
hw/rtl/cmbi_pkg.sv
hw/rtl/cmbi_regs.sv
hw/rtl/cmbi_core.sv
hw/rtl/cartridge_mapper_bank_irq_top.sv
tb/sv/testbench.sv
